FILE: sv/cor_pkg.sv
// Shared widths, codes and constants for the circle overlap relaxation block.
package cor_pkg;

  // item function codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ITER = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // arithmetic widths
  localparam int MAG_W  = 25;          // radius sum, overlap, in-range deltas
  localparam int PROD_W = 2 * MAG_W;   // one multiplier product
  localparam int DVD_W  = PROD_W + 1;  // doubled product
  localparam int DEN_W  = 27;          // 3 * (dist + 1)
  localparam int ROOT_W = 26;          // floor sqrt of a 51-bit sum
  localparam int Q_W    = 26;          // useful quotient bits
  localparam int CNT_W  = 19;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

FILE: sv/circle_overlap_relaxation_step.sv
// Circle table with load, read and one relaxation step per iterate word.
// Every word returns one result word. An iterate word over n circles runs a clear sweep, a row
// pass for each row with pairs, a box test per pair, the 26-step square root for each pair that
// passes the box test, two divides per overlapping pair, and then a move sweep over the n circles.
// One word in flight; output stalls hold the result. Sync active-low reset clears control, count and out valid.
module circle_overlap_relaxation_step
  import cor_pkg::*;
#(
  parameter int MAX_CIRCLES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [9:0]              in_index,
  input  logic signed [31:0]      in_center_x,
  input  logic signed [31:0]      in_center_y,
  input  logic [23:0]             in_radius,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CNT_W-1:0]        out_overlap_count,
  output logic signed [31:0]      out_read_x,
  output logic signed [31:0]      out_read_y,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);
  localparam logic [31:0] MAXC = 32'(MAX_CIRCLES);

  typedef enum logic [25:0] {
    S_IDLE    = 26'h0000001,
    S_RD_ADDR = 26'h0000002,
    S_RD_LAT  = 26'h0000004,
    S_CLR     = 26'h0000008,
    S_ROW_RD  = 26'h0000010,
    S_ROW_LAT = 26'h0000020,
    S_PAIR_RD = 26'h0000040,
    S_PAIR_LT = 26'h0000080,
    S_TEST    = 26'h0000100,
    S_SQX     = 26'h0000200,
    S_SQY     = 26'h0000400,
    S_SQS     = 26'h0000800,
    S_SQRT    = 26'h0001000,
    S_CMP     = 26'h0002000,
    S_MX      = 26'h0004000,
    S_DXS     = 26'h0008000,
    S_DIVX    = 26'h0010000,
    S_MY      = 26'h0020000,
    S_DYS     = 26'h0040000,
    S_DIVY    = 26'h0080000,
    S_UPD     = 26'h0100000,
    S_NXT     = 26'h0200000,
    S_ROWEND  = 26'h0400000,
    S_MV_RD   = 26'h0800000,
    S_MV_WR   = 26'h1000000,
    S_RES     = 26'h2000000
  } state_t;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    if (v[32] != v[31]) sat32 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else sat32 = v[31:0];
  endfunction

  state_t state_r;

  // configuration
  logic [10:0] cnt_r;
  logic [CW-1:0] n_eff, n_r;
  logic cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {21'd0, cnt_r};
  assign n_eff      = (32'(cnt_r) > MAXC) ? CW'(MAX_CIRCLES) : CW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      cnt_r <= cfg_pwdata[10:0];
    end
  end

  // memories
  logic [31:0] cx_mem [MAX_CIRCLES];
  logic [31:0] cy_mem [MAX_CIRCLES];
  logic [23:0] r_mem  [MAX_CIRCLES];
  logic [31:0] sx_mem [MAX_CIRCLES];
  logic [31:0] sy_mem [MAX_CIRCLES];

  logic [31:0] cx_rd_r, cy_rd_r, sx_rd_r, sy_rd_r;
  logic [23:0] r_rd_r;

  logic accept, idx_ok, ld_we;
  logic [AW-1:0] idx_r, rd_addr, sh_addr;
  logic idx_ok_r;
  logic [CW-1:0] i_r, j_r, k_r;
  logic [CW:0] i_p2, j_p1, k_p1, n_x;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign idx_ok   = 32'(in_index) < MAXC;
  assign ld_we    = accept && (in_func == FUNC_LOAD) && idx_ok;
  assign i_p2     = {1'b0, i_r} + (CW+1)'(2);
  assign j_p1     = {1'b0, j_r} + (CW+1)'(1);
  assign k_p1     = {1'b0, k_r} + (CW+1)'(1);
  assign n_x      = {1'b0, n_r};

  // pair datapath registers
  logic [31:0] xi_r, yi_r, acc_x_r, acc_y_r, shj_x_r, shj_y_r;
  logic [23:0] ri_r;
  logic [32:0] ax_r, ay_r;
  logic [MAG_W-1:0] rsum_r, ov_r;
  logic sgnx_r, sgny_r;
  logic [PROD_W-1:0] mul_r, sum_hold_r;
  logic [MAG_W-1:0] mul_a, mul_b;
  logic [2*ROOT_W-1:0] sqv_r;
  logic [29:0] rem_r, rem_sh, trial;
  logic [ROOT_W-1:0] root_r;
  logic [4:0] sq_step_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0] qx_r, qy_r;
  logic [CNT_W-1:0] pairs_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic [31:0] res_x_r, res_y_r;
  logic [32:0] dx, dy, sxv, syv;
  logic [31:0] shj_x_nxt, shj_y_nxt, acc_x_nxt, acc_y_nxt, mv_x, mv_y;
  logic [ROOT_W:0] dist_p1;
  logic [MAG_W:0] d1;
  logic [DEN_W-1:0] den_nxt;

  // divider
  logic div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_q;

  assign div_start = (state_r == S_DXS) || (state_r == S_DYS);

  cor_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mul_r, 1'b0}),
    .divisor  (den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory addresses
  always_comb begin
    unique case (state_r)
      S_ROW_RD: rd_addr = i_r[AW-1:0];
      S_PAIR_RD: rd_addr = j_r[AW-1:0];
      S_MV_RD:  rd_addr = k_r[AW-1:0];
      default:  rd_addr = idx_r;
    endcase
    unique case (state_r)
      S_CLR:    sh_addr = k_r[AW-1:0];
      S_UPD:    sh_addr = j_r[AW-1:0];
      default:  sh_addr = i_r[AW-1:0];
    endcase
  end

  // circle table: load writes, move sweep writes, one read port
  always_ff @(posedge clk) begin
    if (ld_we) begin
      cx_mem[AW'(in_index)] <= in_center_x;
      cy_mem[AW'(in_index)] <= in_center_y;
      r_mem[AW'(in_index)]  <= in_radius;
    end else if (state_r == S_MV_WR) begin
      cx_mem[k_r[AW-1:0]] <= mv_x;
      cy_mem[k_r[AW-1:0]] <= mv_y;
    end
    cx_rd_r <= cx_mem[rd_addr];
    cy_rd_r <= cy_mem[rd_addr];
    r_rd_r  <= r_mem[rd_addr];
  end

  // displacement table: clear, pair update, row write-back
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      sx_mem[sh_addr] <= '0;
      sy_mem[sh_addr] <= '0;
    end else if (state_r == S_UPD) begin
      sx_mem[sh_addr] <= shj_x_nxt;
      sy_mem[sh_addr] <= shj_y_nxt;
    end else if (state_r == S_ROWEND) begin
      sx_mem[sh_addr] <= acc_x_r;
      sy_mem[sh_addr] <= acc_y_r;
    end
    sx_rd_r <= sx_mem[rd_addr];
    sy_rd_r <= sy_mem[rd_addr];
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = ax_r[MAG_W-1:0]; mul_b = ax_r[MAG_W-1:0]; end
      S_SQY:   begin mul_a = ay_r[MAG_W-1:0]; mul_b = ay_r[MAG_W-1:0]; end
      S_MX:    begin mul_a = ov_r;            mul_b = ax_r[MAG_W-1:0]; end
      default: begin mul_a = ov_r;            mul_b = ay_r[MAG_W-1:0]; end
    endcase
  end

  // combinational helpers
  always_comb begin
    dx        = {cx_rd_r[31], cx_rd_r} - {xi_r[31], xi_r};
    dy        = {cy_rd_r[31], cy_rd_r} - {yi_r[31], yi_r};
    rem_sh    = {rem_r[27:0], sqv_r[2*ROOT_W-1 -: 2]};
    trial     = {2'b00, root_r, 2'b01};
    dist_p1   = {1'b0, root_r} + (ROOT_W+1)'(1);
    d1        = {1'b0, root_r[MAG_W-1:0]} + (MAG_W+1)'(1);
    den_nxt   = {d1, 1'b0} + {1'b0, d1};
    sxv       = sgnx_r ? -{7'd0, qx_r} : {7'd0, qx_r};
    syv       = sgny_r ? -{7'd0, qy_r} : {7'd0, qy_r};
    shj_x_nxt = sat32({shj_x_r[31], shj_x_r} + sxv);
    shj_y_nxt = sat32({shj_y_r[31], shj_y_r} + syv);
    acc_x_nxt = sat32({acc_x_r[31], acc_x_r} - sxv);
    acc_y_nxt = sat32({acc_y_r[31], acc_y_r} - syv);
    mv_x      = sat32({cx_rd_r[31], cx_rd_r} + {sx_rd_r[31], sx_rd_r});
    mv_y      = sat32({cy_rd_r[31], cy_rd_r} + {sy_rd_r[31], sy_rd_r});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_func)
              FUNC_ITER: state_r <= (n_eff == '0) ? S_RES : S_CLR;
              FUNC_READ: state_r <= S_RD_ADDR;
              default:   state_r <= S_RES;
            endcase
          end
        end
        S_RD_ADDR: state_r <= S_RD_LAT;
        S_RD_LAT:  state_r <= S_RES;
        S_CLR: begin
          if (k_p1 == n_x) state_r <= (n_x >= (CW+1)'(2)) ? S_ROW_RD : S_MV_RD;
        end
        S_ROW_RD:  state_r <= S_ROW_LAT;
        S_ROW_LAT: state_r <= S_PAIR_RD;
        S_PAIR_RD: state_r <= S_PAIR_LT;
        S_PAIR_LT: state_r <= S_TEST;
        S_TEST: begin
          if ((ax_r >= {8'd0, rsum_r}) || (ay_r >= {8'd0, rsum_r})) state_r <= S_NXT;
          else state_r <= S_SQX;
        end
        S_SQX:  state_r <= S_SQY;
        S_SQY:  state_r <= S_SQS;
        S_SQS:  state_r <= S_SQRT;
        S_SQRT: if (sq_step_r == 5'(ROOT_W - 1)) state_r <= S_CMP;
        S_CMP: begin
          if (dist_p1 >= {2'b00, rsum_r}) state_r <= S_NXT;
          else state_r <= S_MX;
        end
        S_MX:   state_r <= S_DXS;
        S_DXS:  state_r <= S_DIVX;
        S_DIVX: if (div_done) state_r <= S_MY;
        S_MY:   state_r <= S_DYS;
        S_DYS:  state_r <= S_DIVY;
        S_DIVY: if (div_done) state_r <= S_UPD;
        S_UPD:  state_r <= S_NXT;
        S_NXT:  state_r <= (j_p1 < n_x) ? S_PAIR_RD : S_ROWEND;
        S_ROWEND: state_r <= (i_p2 < n_x) ? S_ROW_RD : S_MV_RD;
        S_MV_RD: state_r <= S_MV_WR;
        S_MV_WR: if (k_p1 == n_x) state_r <= S_RES;
                 else state_r <= S_MV_RD;
        S_RES: if (!out_valid || !out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath and loop counters
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_r     <= AW'(in_index);
          idx_ok_r  <= idx_ok;
          n_r       <= n_eff;
          k_r       <= '0;
          pairs_r   <= '0;
          res_cnt_r <= '0;
          res_x_r   <= '0;
          res_y_r   <= '0;
        end
      end
      S_RD_LAT: begin
        res_x_r <= idx_ok_r ? cx_rd_r : 32'd0;
        res_y_r <= idx_ok_r ? cy_rd_r : 32'd0;
      end
      S_CLR: begin
        if (k_p1 == n_x) begin
          k_r <= '0;
          i_r <= '0;
          j_r <= CW'(1);
        end else begin
          k_r <= k_p1[CW-1:0];
        end
      end
      S_ROW_LAT: begin
        xi_r    <= cx_rd_r;
        yi_r    <= cy_rd_r;
        ri_r    <= r_rd_r;
        acc_x_r <= sx_rd_r;
        acc_y_r <= sy_rd_r;
      end
      S_PAIR_LT: begin
        ax_r    <= dx[32] ? -dx : dx;
        ay_r    <= dy[32] ? -dy : dy;
        sgnx_r  <= dx[32];
        sgny_r  <= dy[32];
        rsum_r  <= {1'b0, ri_r} + {1'b0, r_rd_r};
        shj_x_r <= sx_rd_r;
        shj_y_r <= sy_rd_r;
      end
      S_SQY: sum_hold_r <= mul_r;
      S_SQS: begin
        sqv_r     <= {1'b0, {1'b0, sum_hold_r} + {1'b0, mul_r}};
        rem_r     <= '0;
        root_r    <= '0;
        sq_step_r <= '0;
      end
      S_SQRT: begin
        sqv_r     <= {sqv_r[2*ROOT_W-3:0], 2'b00};
        sq_step_r <= sq_step_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      S_CMP: begin
        ov_r  <= rsum_r - root_r[MAG_W-1:0];
        den_r <= den_nxt;
        if (dist_p1 < {2'b00, rsum_r} && pairs_r != COUNT_MAX) pairs_r <= pairs_r + 1'b1;
      end
      S_DIVX: if (div_done) qx_r <= div_q[Q_W-1:0];
      S_DIVY: if (div_done) qy_r <= div_q[Q_W-1:0];
      S_UPD: begin
        acc_x_r <= acc_x_nxt;
        acc_y_r <= acc_y_nxt;
      end
      S_NXT: if (j_p1 < n_x) j_r <= j_p1[CW-1:0];
      S_ROWEND: begin
        if (i_p2 < n_x) begin
          i_r <= i_r + 1'b1;
          j_r <= i_p2[CW-1:0];
        end else begin
          k_r <= '0;
        end
      end
      S_MV_WR: begin
        k_r <= k_p1[CW-1:0];
        if (k_p1 == n_x) res_cnt_r <= pairs_r;
      end
      default: ;
    endcase
  end

  // output register: hold the word until taken
  logic out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [31:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RES && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES && (!out_valid_r || !out_stall)) begin
      out_cnt_r <= res_cnt_r;
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_overlap_count = out_cnt_r;
  assign out_read_x        = out_x_r;
  assign out_read_y        = out_y_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("block took a word without going busy");

  a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RES))
    else $error("result word raised outside the result state");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

FILE: sv/cor_div.sv
// Restoring divider, one quotient bit per cycle.
module cor_div
  import cor_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, den_r};
    qbit    = ~diff[DEN_W+1];
    rem_nxt = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // control: load on start, count steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // datapath: shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

FILE: tb/sv/tb_circle_overlap_relaxation_step.sv
// Testbench for the circle overlap relaxation step block: directed table and random words.
`timescale 1ns / 1ps
module tb_circle_overlap_relaxation_step
  import cor_pkg::*;
;

  localparam int TABLE_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]         func;
    logic [9:0]         index;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [23:0]        radius;
  } circle_word_t;

  typedef struct {
    logic [CNT_W-1:0]   count;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
  } center_word_t;

  // Directed row: stimulus plus an optional hand-typed result.
  typedef struct {
    circle_word_t w;
    bit           typed;
    center_word_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [9:0] in_index = '0;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic [23:0] in_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_overlap_count;
  logic signed [31:0] out_read_x;
  logic signed [31:0] out_read_y;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  circle_overlap_relaxation_step dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] pos_x [TABLE_SLOTS];
  logic signed [31:0] pos_y [TABLE_SLOTS];
  logic [23:0]        rad   [TABLE_SLOTS];
  bit                 loaded [TABLE_SLOTS];
  int unsigned        live_circles;
  center_word_t       pending_centers [$];
  int                 errors = 0;
  int unsigned        cycles = 0;
  bit                 hold_off = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // One relaxation step over the live circles; returns overlapping pairs.
  function automatic logic [CNT_W-1:0] relax_step();
    logic signed [31:0] sh_x [TABLE_SLOTS];
    logic signed [31:0] sh_y [TABLE_SLOTS];
    int unsigned n, pairs;
    longint dx, dy, sx, sy;
    longint unsigned ax, ay, rsum, root_len, ov, den;
    n = (live_circles > TABLE_SLOTS) ? TABLE_SLOTS : live_circles;
    pairs = 0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      sh_x[k] = 0;
      sh_y[k] = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = longint'(pos_x[j]) - longint'(pos_x[i]);
        dy = longint'(pos_y[j]) - longint'(pos_y[i]);
        rsum = longint'(rad[i]) + longint'(rad[j]);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= rsum || ay >= rsum) continue;
        root_len = isqrt(ax * ax + ay * ay);
        if (root_len + 1 >= rsum) continue;
        if (pairs < COUNT_MAX) pairs++;
        ov = rsum - root_len;
        den = 3 * (root_len + 1);
        sx = longint'((2 * ov * ax) / den);
        sy = longint'((2 * ov * ay) / den);
        if (dx < 0) sx = -sx;
        if (dy < 0) sy = -sy;
        sh_x[i] = clamp32(longint'(sh_x[i]) - sx);
        sh_y[i] = clamp32(longint'(sh_y[i]) - sy);
        sh_x[j] = clamp32(longint'(sh_x[j]) + sx);
        sh_y[j] = clamp32(longint'(sh_y[j]) + sy);
      end
    end
    for (int i = 0; i < n; i++) begin
      pos_x[i] = clamp32(longint'(pos_x[i]) + sh_x[i]);
      pos_y[i] = clamp32(longint'(pos_y[i]) + sh_y[i]);
    end
    return pairs[CNT_W-1:0];
  endfunction

  function automatic center_word_t predict_center(circle_word_t w);
    center_word_t r;
    r = '{default: '0};
    case (w.func)
      FUNC_LOAD: begin
        pos_x[w.index] = w.cx;
        pos_y[w.index] = w.cy;
        rad[w.index] = w.radius;
        loaded[w.index] = 1'b1;
      end
      FUNC_ITER: r.count = relax_step();
      FUNC_READ: begin
        r.rx = pos_x[w.index];
        r.ry = pos_y[w.index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receive side: random stalls, plus the long hold-off when asked.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 7);
      if (hold_off) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= hold_off;
      @(posedge clk);
      while (hold_off) @(posedge clk);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    center_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_centers.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        e = pending_centers.pop_front();
        if (out_overlap_count !== e.count) begin
          $error("overlap_count exp %0d got %0d", e.count, out_overlap_count);
          errors++;
        end
        if (out_read_x !== e.rx) begin
          $error("read_x exp %0d got %0d", e.rx, out_read_x);
          errors++;
        end
        if (out_read_y !== e.ry) begin
          $error("read_y exp %0d got %0d", e.ry, out_read_y);
          errors++;
        end
      end
    end
  end

  task automatic write_count(int unsigned value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    live_circles = value & 32'h7ff;
    @(posedge clk);
  endtask

  // Drain expectations and let the block settle before a register write.
  task automatic drain();
    while (pending_centers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(circle_word_t w, bit typed, center_word_t r, bit no_gap);
    center_word_t p;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= w.func;
    in_index <= w.index;
    in_center_x <= w.cx;
    in_center_y <= w.cy;
    in_radius <= w.radius;
    @(posedge clk iff !in_stall);
    p = predict_center(w);
    pending_centers.push_back(typed ? r : p);
  endtask

  task automatic finish_words();
    in_valid <= 1'b0;
  endtask

  function automatic circle_word_t mk(logic [1:0] f, int idx, int x, int y, int r);
    circle_word_t w;
    w.func = f;
    w.index = 10'(idx);
    w.cx = x;
    w.cy = y;
    w.radius = 24'(r);
    return w;
  endfunction

  // Random word; loads and reads stay on slots below span.
  function automatic circle_word_t random_word(int unsigned span);
    circle_word_t w;
    int unsigned pick, idx;
    pick = $urandom_range(0, 9);
    idx = $urandom_range(0, span - 1);
    w = mk(FUNC_LOAD, idx, 0, 0, 0);
    if (pick < 5) begin
      w.cx = $urandom_range(0, 32'h60000) - 32'h30000;
      w.cy = $urandom_range(0, 32'h60000) - 32'h30000;
      w.radius = 24'($urandom_range(0, 24'h30000));
      if ($urandom_range(0, 7) == 0) begin
        w.cx = $urandom;
        w.cy = $urandom;
        w.radius = 24'($urandom);
      end
    end else if (pick < 7) begin
      w.func = FUNC_READ;
    end else if (pick < 9) begin
      w.func = FUNC_ITER;
    end else begin
      w.func = 2'd3;
      w.index = 10'($urandom);
      w.cx = $urandom;
      w.cy = $urandom;
      w.radius = 24'($urandom);
    end
    return w;
  endfunction

  initial begin
    row_t rows [$];
    center_word_t z;
    circle_word_t w;
    z = '{default: '0};
    live_circles = 0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      pos_x[k] = 0;
      pos_y[k] = 0;
      rad[k] = 0;
      loaded[k] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every function, saturation, unused code.
    rows.push_back('{mk(FUNC_ITER, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk(2'd3, 10'h3ff, -1, -1, 24'hffffff), 1, z});
    rows.push_back('{mk(FUNC_LOAD, 0, 32'sh7fffff00, 32'sh80000100, 24'hffffff), 1, z});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 1,
                     '{0, 32'sh7fffff00, 32'sh80000100}});
    rows.push_back('{mk(FUNC_LOAD, 1, 32'sh7fffffff, 32'sh80000000, 24'hffffff), 1, z});
    rows.push_back('{mk(FUNC_LOAD, 1023, 0, 0, 24'hffffff), 1, z});
    rows.push_back('{mk(FUNC_READ, 1023, 0, 0, 0), 1, z});
    rows.push_back('{mk(FUNC_LOAD, 2, 0, 0, 24'h10000), 0, z});
    rows.push_back('{mk(FUNC_LOAD, 3, 1, 0, 24'h10000), 0, z});
    rows.push_back('{mk(FUNC_LOAD, 4, 0, 32'h20000, 1), 0, z});
    rows.push_back('{mk(FUNC_LOAD, 5, -32'h10000, -32'h10000, 24'h8000), 0, z});
    foreach (rows[k]) send_word(rows[k].w, rows[k].typed, rows[k].r, 1'b0);
    finish_words();
    drain();
    write_count(4);
    rows.delete();
    rows.push_back('{mk(FUNC_ITER, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(FUNC_READ, 1, 0, 0, 0), 0, z});
    rows.push_back('{mk(FUNC_READ, 3, 0, 0, 0), 0, z});
    rows.push_back('{mk(FUNC_ITER, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk(FUNC_READ, 2, 0, 0, 0), 0, z});
    foreach (rows[k]) send_word(rows[k].w, rows[k].typed, rows[k].r, 1'b0);
    finish_words();
    drain();

    // Three iterate steps over six circles, and a single circle.
    write_count(6);
    for (int k = 0; k < 3; k++) send_word(mk(FUNC_ITER, 0, 0, 0, 0), 0, z, 1'b0);
    send_word(mk(FUNC_READ, 5, 0, 0, 0), 0, z, 1'b0);
    finish_words();
    drain();
    write_count(1);
    send_word(mk(FUNC_ITER, 0, 0, 0, 0), 1, z, 1'b0);
    finish_words();
    drain();

    // Random phase on a small table.
    write_count(16);
    for (int k = 0; k < 16; k++) begin
      w = mk(FUNC_LOAD, k, $urandom_range(0, 32'h40000) - 32'h20000,
             $urandom_range(0, 32'h40000) - 32'h20000, $urandom_range(0, 24'h20000));
      send_word(w, 0, z, 1'b0);
    end
    for (int k = 0; k < 20; k++) send_word(random_word(16), 0, z, 1'b0);

    // Long receiver hold-off while words keep coming back to back.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 8; k++) send_word(mk(FUNC_READ, k, 0, 0, 0), 0, z, 1'b1);
    join
    finish_words();
    drain();

    // Count above the table and at the top of its range, with few live slots.
    write_count(2047);
    write_count(3);
    for (int k = 0; k < 30; k++) send_word(random_word(3), 0, z, 1'b0);
    finish_words();
    drain();
    write_count(0);
    send_word(mk(FUNC_ITER, 0, 0, 0, 0), 1, z, 1'b0);
    send_word(mk(FUNC_READ, 1023, 0, 0, 0), 0, z, 1'b0);
    finish_words();

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: circle_overlap_relaxation_step.f
sv/cor_pkg.sv
sv/cor_div.sv
sv/circle_overlap_relaxation_step.sv
tb/sv/tb_circle_overlap_relaxation_step.sv
